// ===== hdl/ray_box_slab_test_core_macros.svh =====
// Assertion macros shared by the ray/box slab test RTL.
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define RBST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbst check failed");

// Next-cycle implication, off during reset.
`define RBST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbst check failed");

`endif

// ===== hdl/rbst_pkg.sv =====
// Shared constants and types for the ray/box slab test.
package rbst_pkg;

  localparam int AXES  = 3;
  localparam int Q_W   = 32;               // Q16.16 word
  localparam int FRAC  = 16;
  localparam int DIF_W = Q_W + 1;          // bound - origin, exact
  localparam int NUM_W = DIF_W + FRAC;     // |diff| << 16
  localparam int T_W   = Q_W + 2;          // room for "no limit" codes

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [Q_W-1:0]   den_t;
  typedef logic signed [T_W-1:0] tval_t;

  localparam tval_t NO_ENTRY = -(tval_t'(1) <<< Q_W);
  localparam tval_t NO_EXIT  =  (tval_t'(1) <<< Q_W);

  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_e;

endpackage

// ===== hdl/rbst_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rbst_div_pipe (
  input  logic          clk_i,
  input  logic          en_i,
  input  rbst_pkg::num_t num_i,
  input  rbst_pkg::den_t den_i,
  output rbst_pkg::num_t quo_o
);
  import rbst_pkg::*;

  num_t num_q [NUM_W];
  num_t quo_q [NUM_W];
  den_t rem_q [NUM_W];
  den_t den_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stg
    num_t             num_in;
    num_t             quo_in;
    den_t             rem_in;
    den_t             den_in;
    logic [Q_W:0]     cand;
    logic [Q_W:0]     sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    // remainder stays below the divisor, so 33 bits hold the trial value
    assign cand = {rem_in, num_in[NUM_W-1]};
    assign sub  = cand - {1'b0, den_in};
    assign ge   = cand >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[NUM_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[NUM_W-2:0], ge};
        rem_q[k] <= ge ? sub[Q_W-1:0] : cand[Q_W-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];

endmodule

// ===== hdl/ray_box_slab_test_core.sv =====
// Ray versus axis-aligned box slab test, fully pipelined.
// Stages: an accepted word is loaded into the input stage, then passes
//   through 49 divider stages, saturate, reduce and the output register.
// Throughput: one ray per cycle while the output is not held; six dividers run side by side.
// The whole pipe advances unless the output word is held by out_stall_i.
// Reset (rst_ni low, async) clears all valid bits and the box bounds to 0.
module ray_box_slab_test_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [rbst_pkg::Q_W-1:0] cfg_data_i,
  // ray input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [31:0]      origin_x_i,
  input  logic signed [31:0]      origin_y_i,
  input  logic signed [31:0]      origin_z_i,
  input  logic signed [31:0]      dir_x_i,
  input  logic signed [31:0]      dir_y_i,
  input  logic signed [31:0]      dir_z_i,
  // result
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o
);
  import rbst_pkg::*;
  `include "ray_box_slab_test_core_macros.svh"

  localparam int NDIV = 2 * AXES;   // lo and hi per axis

  // ---------------- box bound registers ----------------
  logic signed [Q_W-1:0] box_lo_q [AXES];
  logic signed [Q_W-1:0] box_hi_q [AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo_q[a] <= '0;
        box_hi_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_X: box_lo_q[0] <= cfg_data_i;
        CFG_MIN_Y: box_lo_q[1] <= cfg_data_i;
        CFG_MIN_Z: box_lo_q[2] <= cfg_data_i;
        CFG_MAX_X: box_hi_q[0] <= cfg_data_i;
        CFG_MAX_Y: box_hi_q[1] <= cfg_data_i;
        CFG_MAX_Z: box_hi_q[2] <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- global advance ----------------
  // The output register is the only place a word can wait; when it is
  // held, every stage holds with it, so nothing is lost or doubled.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 1: slab differences ----------------
  logic signed [Q_W-1:0] org [AXES];
  logic signed [Q_W-1:0] dir [AXES];
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  num_t        num_d [NDIV];
  den_t        den_d [AXES];
  logic [NDIV-1:0] neg_d;
  logic [AXES-1:0] dz_d;
  logic        miss_d;

  always_comb begin
    logic signed [DIF_W-1:0] dlo;
    logic signed [DIF_W-1:0] dhi;
    logic [DIF_W-1:0]        mlo;
    logic [DIF_W-1:0]        mhi;
    miss_d = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      dlo = DIF_W'(box_lo_q[a]) - DIF_W'(org[a]);
      dhi = DIF_W'(box_hi_q[a]) - DIF_W'(org[a]);
      mlo = dlo[DIF_W-1] ? DIF_W'(-dlo) : DIF_W'(dlo);
      mhi = dhi[DIF_W-1] ? DIF_W'(-dhi) : DIF_W'(dhi);
      num_d[a]        = {mlo, {FRAC{1'b0}}};
      num_d[a + AXES] = {mhi, {FRAC{1'b0}}};
      neg_d[a]        = dlo[DIF_W-1] ^ dir[a][Q_W-1];
      neg_d[a + AXES] = dhi[DIF_W-1] ^ dir[a][Q_W-1];
      den_d[a]  = dir[a][Q_W-1] ? den_t'(-dir[a]) : den_t'(dir[a]);
      dz_d[a]   = (dir[a] == '0);
      // flat axis: origin must lie inside the slab
      if (dz_d[a] && ((org[a] < box_lo_q[a]) || (org[a] > box_hi_q[a]))) begin
        miss_d = 1'b1;
      end
    end
  end

  logic            s1_valid_q;
  num_t            s1_num_q [NDIV];
  den_t            s1_den_q [AXES];
  logic [NDIV-1:0] s1_neg_q;
  logic [AXES-1:0] s1_dz_q;
  logic            s1_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_num_q  <= num_d;
      s1_den_q  <= den_d;
      s1_neg_q  <= neg_d;
      s1_dz_q   <= dz_d;
      s1_miss_q <= miss_d;
    end
  end

  // ---------------- divider bank ----------------
  num_t quo [NDIV];
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    rbst_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s1_num_q[i]),
      .den_i (s1_den_q[i % AXES]),
      .quo_o (quo[i])
    );
  end

  // sideband travels alongside the dividers
  logic            sb_valid_q [NUM_W];
  logic [NDIV-1:0] sb_neg_q   [NUM_W];
  logic [AXES-1:0] sb_dz_q    [NUM_W];
  logic            sb_miss_q  [NUM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_W; k++) sb_valid_q[k] <= 1'b0;
    end else if (en) begin
      sb_valid_q[0] <= s1_valid_q;
      for (int k = 1; k < NUM_W; k++) sb_valid_q[k] <= sb_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_neg_q[0]  <= s1_neg_q;
      sb_dz_q[0]   <= s1_dz_q;
      sb_miss_q[0] <= s1_miss_q;
      for (int k = 1; k < NUM_W; k++) begin
        sb_neg_q[k]  <= sb_neg_q[k-1];
        sb_dz_q[k]   <= sb_dz_q[k-1];
        sb_miss_q[k] <= sb_miss_q[k-1];
      end
    end
  end

  // ---------------- P1: saturate, order per axis ----------------
  localparam num_t QPOS_MAX = num_t'((64'd1 << (Q_W - 1)) - 64'd1);

  tval_t q_sat [NDIV];
  tval_t ent_d [AXES];
  tval_t lev_d [AXES];

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      if (sb_neg_q[NUM_W-1][i]) begin
        q_sat[i] = (quo[i] > QPOS_MAX) ? -(tval_t'(1) <<< (Q_W - 1))
                                       : -tval_t'(quo[i][Q_W-1:0]);
      end else begin
        q_sat[i] = (quo[i] > QPOS_MAX) ? tval_t'(QPOS_MAX[Q_W-1:0])
                                       : tval_t'(quo[i][Q_W-1:0]);
      end
    end
    for (int a = 0; a < AXES; a++) begin
      if (sb_dz_q[NUM_W-1][a]) begin
        ent_d[a] = NO_ENTRY;
        lev_d[a] = NO_EXIT;
      end else if (q_sat[a] < q_sat[a + AXES]) begin
        ent_d[a] = q_sat[a];
        lev_d[a] = q_sat[a + AXES];
      end else begin
        ent_d[a] = q_sat[a + AXES];
        lev_d[a] = q_sat[a];
      end
    end
  end

  logic  p1_valid_q;
  tval_t p1_ent_q [AXES];
  tval_t p1_lev_q [AXES];
  logic  p1_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= sb_valid_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_ent_q  <= ent_d;
      p1_lev_q  <= lev_d;
      p1_miss_q <= sb_miss_q[NUM_W-1];
    end
  end

  // ---------------- P2: tmin / tmax ----------------
  tval_t tmin_d;
  tval_t tmax_d;

  always_comb begin
    tmin_d = NO_ENTRY;
    tmax_d = NO_EXIT;
    for (int a = 0; a < AXES; a++) begin
      if (p1_ent_q[a] > tmin_d) tmin_d = p1_ent_q[a];
      if (p1_lev_q[a] < tmax_d) tmax_d = p1_lev_q[a];
    end
  end

  logic  p2_valid_q;
  tval_t p2_tmin_q;
  tval_t p2_tmax_q;
  logic  p2_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_tmin_q <= tmin_d;
      p2_tmax_q <= tmax_d;
      p2_miss_q <= p1_miss_q;
    end
  end

  // ---------------- output register ----------------
  logic hit_d;
  assign hit_d = !p2_miss_q && (p2_tmax_q > 0) && (p2_tmin_q < p2_tmax_q);

  logic out_valid_q;
  logic hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) hit_q <= hit_d;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  // ---------------- checks ----------------
  `RBST_ASSERT_NXT(a_miss_kills_hit, clk_i, rst_ni, p2_valid_q && en && p2_miss_q, !hit_o)
  `RBST_ASSERT_NXT(a_div_to_p1, clk_i, rst_ni, sb_valid_q[NUM_W-1] && en, p1_valid_q)
  `RBST_ASSERT_NXT(a_hold_p1, clk_i, rst_ni, !en, $stable(p1_valid_q) && $stable(p2_valid_q))

endmodule
